@@ sv/acep_pkg.sv @@
// Shared types and constants for the ANSI CSI escape parser.
// Used by acep_params, acep_decode and ansi_csi_escape_parser.
package acep_pkg;

    localparam int ARG_W    = 17;
    localparam int RES_W    = 51;
    localparam int TDATA_W  = 56;
    localparam int IN_W     = 8;

    localparam logic [7:0] CHAR_ESC   = 8'h1B;
    localparam logic [7:0] CHAR_LBRK  = 8'h5B;
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] CHAR_K     = 8'h4B;
    localparam logic [7:0] CHAR_M     = 8'h6D;
    localparam logic [7:0] CHAR_J     = 8'h4A;
    localparam logic [7:0] CHAR_BS    = 8'h08;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_TWO   = 8'h32;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] FG_BASE    = 8'd30;
    localparam logic [7:0] FG_TOP     = 8'd37;

    typedef enum logic [3:0] {
        CMD_NONE       = 4'd0,
        CMD_PRINT      = 4'd1,
        CMD_BACKSPACE  = 4'd2,
        CMD_RETURN     = 4'd3,
        CMD_NEWLINE    = 4'd4,
        CMD_ERASE_LINE = 4'd5,
        CMD_ERASE_EOL  = 4'd6,
        CMD_ERASE_DOWN = 4'd7,
        CMD_ATTR       = 4'd8,
        CMD_HOME       = 4'd9
    } cmd_t;

    // Result beat, lowest field in the lowest bits.
    typedef struct packed {
        logic [ARG_W-1:0] arg1;
        logic [ARG_W-1:0] arg0;
        logic [2:0]       fg_color;
        logic             fg_valid;
        logic             reset_attr;
        logic [7:0]       char_code;
        cmd_t             command;
    } res_t;

    typedef struct packed {
        logic clear;
        logic take;
    } par_ctrl_t;

    typedef struct packed {
        logic             first_is_two;
        logic             first_is_zero;
        logic             reset_attr;
        logic             fg_valid;
        logic [2:0]       fg_color;
        logic [ARG_W-1:0] arg0;
        logic [ARG_W-1:0] arg1;
    } par_info_t;

    function automatic logic is_cursor_final(input logic [7:0] ch);
        return ch inside {"A", "B", "C", "D", "i", "r", "n", "c", "H"};
    endfunction

endpackage

@@ sv/acep_params.sv @@
// CSI parameter collector: first parameter byte, two decimal fields.
// Depends on acep_pkg.
module acep_params
    import acep_pkg::*;
#(
    parameter int unsigned FIELD_BITS = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  par_ctrl_t ctrl,
    input  logic [7:0] ch,
    output par_info_t info
);

    localparam int ACC_W = FIELD_BITS + 4;
    localparam logic [1:0] SLOT_FIRST = 2'd0;
    localparam logic [1:0] SLOT_DONE  = 2'd2;

    logic [7:0]            first_reg, first_next;
    logic [1:0]            slot_reg, slot_next;
    logic [1:0]            seen_reg, seen_next;
    logic [1:0]            bad_reg, bad_next;
    logic [FIELD_BITS-1:0] value_reg [2];
    logic [FIELD_BITS-1:0] value_next [2];
    logic [FIELD_BITS-1:0] cur_value;
    logic [ACC_W-1:0]      acc_wide;
    logic [FIELD_BITS-1:0] acc_sat;
    logic                  is_digit;

    assign is_digit  = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
    assign cur_value = value_reg[slot_reg[0]];
    assign acc_wide  = ({4'b0, cur_value} << 3) + ({4'b0, cur_value} << 1)
                     + ACC_W'(ch[3:0]);
    assign acc_sat   = (|acc_wide[ACC_W-1 -: 4]) ? '1 : acc_wide[FIELD_BITS-1:0];

    always_comb begin
        first_next = first_reg;
        slot_next  = slot_reg;
        seen_next  = seen_reg;
        bad_next   = bad_reg;
        value_next = value_reg;
        if (ctrl.clear) begin
            first_next    = '0;
            slot_next     = SLOT_FIRST;
            seen_next     = '0;
            bad_next      = '0;
            value_next[0] = '0;
            value_next[1] = '0;
        end else if (ctrl.take) begin
            if (slot_reg == SLOT_FIRST && !seen_reg[0]) begin
                first_next = ch;
            end
            if (ch == CHAR_SEMI) begin
                if (slot_reg < SLOT_DONE) begin
                    slot_next = slot_reg + 2'd1;
                end
            end else if (slot_reg < SLOT_DONE) begin
                seen_next[slot_reg[0]] = 1'b1;
                if (is_digit) begin
                    value_next[slot_reg[0]] = acc_sat;
                end else begin
                    bad_next[slot_reg[0]] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg    <= '0;
            slot_reg     <= SLOT_FIRST;
            seen_reg     <= '0;
            bad_reg      <= '0;
            value_reg[0] <= '0;
            value_reg[1] <= '0;
        end else begin
            first_reg    <= first_next;
            slot_reg     <= slot_next;
            seen_reg     <= seen_next;
            bad_reg      <= bad_next;
            value_reg[0] <= value_next[0];
            value_reg[1] <= value_next[1];
        end
    end

    always_comb begin
        info.first_is_two  = (first_reg == CHAR_TWO);
        info.first_is_zero = (first_reg == CHAR_ZERO);
        info.arg0 = !seen_reg[0] ? '1 :
                    bad_reg[0] ? '0 : ARG_W'({{ARG_W{1'b0}}, value_reg[0]});
        info.arg1 = !seen_reg[1] ? '1 :
                    bad_reg[1] ? '0 : ARG_W'({{ARG_W{1'b0}}, value_reg[1]});
        info.reset_attr = seen_reg[0] && (bad_reg[0] || value_reg[0] == '0);
        info.fg_valid   = seen_reg[1] && !bad_reg[1]
                       && (value_reg[1] >= FIELD_BITS'(FG_BASE))
                       && (value_reg[1] <= FIELD_BITS'(FG_TOP));
        info.fg_color   = info.fg_valid ? (value_reg[1][2:0] - FG_BASE[2:0]) : 3'd0;
    end

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.clear |=> slot_reg == SLOT_FIRST && seen_reg == '0 && bad_reg == '0)
        else $error("parameter fields not cleared");

endmodule

@@ sv/acep_decode.sv @@
// Parser mode tracking and command decode for one registered byte.
// Depends on acep_pkg; drives acep_params through par_ctrl_t.
module acep_decode
    import acep_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       advance,
    input  logic [7:0] byte_q,
    input  par_info_t  info,
    output par_ctrl_t  ctrl,
    output res_t       res
);

    typedef enum logic [1:0] {
        MODE_TEXT = 2'd0,
        MODE_ESC  = 2'd1,
        MODE_CSI  = 2'd2
    } mode_t;

    mode_t mode_reg, mode_next;
    logic  clear_req, take_req;

    always_comb begin
        res       = '0;
        mode_next = mode_reg;
        clear_req = 1'b0;
        take_req  = 1'b0;
        case (mode_reg)
            MODE_CSI: begin
                case (byte_q)
                    CHAR_K: begin
                        if (info.first_is_two) begin
                            res.command = CMD_ERASE_LINE;
                        end else if (info.first_is_zero) begin
                            res.command = CMD_ERASE_EOL;
                        end
                        mode_next = MODE_TEXT;
                    end
                    CHAR_M: begin
                        res.command    = CMD_ATTR;
                        res.arg0       = info.arg0;
                        res.arg1       = info.arg1;
                        res.reset_attr = info.reset_attr;
                        res.fg_valid   = info.fg_valid;
                        res.fg_color   = info.fg_color;
                        mode_next      = MODE_TEXT;
                    end
                    CHAR_J: begin
                        res.command = CMD_ERASE_DOWN;
                        mode_next   = MODE_TEXT;
                    end
                    default: begin
                        if (is_cursor_final(byte_q)) begin
                            res.command = CMD_HOME;
                            res.arg0    = info.arg0;
                            res.arg1    = info.arg1;
                            mode_next   = MODE_TEXT;
                        end else begin
                            take_req = 1'b1;
                        end
                    end
                endcase
            end
            default: begin
                case (byte_q)
                    CHAR_ESC: mode_next = MODE_ESC;
                    CHAR_LBRK: begin
                        if (mode_reg == MODE_ESC) begin
                            mode_next = MODE_CSI;
                            clear_req = 1'b1;
                        end
                    end
                    CHAR_BS: res.command = CMD_BACKSPACE;
                    CHAR_CR: res.command = CMD_RETURN;
                    CHAR_LF: res.command = CMD_NEWLINE;
                    default: begin
                        res.command   = CMD_PRINT;
                        res.char_code = byte_q;
                    end
                endcase
            end
        endcase
    end

    assign ctrl.clear = advance && clear_req;
    assign ctrl.take  = advance && take_req;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_TEXT;
        end else if (advance) begin
            mode_reg <= mode_next;
        end
    end

    a_esc_arms: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && byte_q == CHAR_ESC && mode_reg != MODE_CSI |=> mode_reg == MODE_ESC)
        else $error("escape byte did not arm the parser");

    a_attr_only: assert property (@(posedge aclk) disable iff (!aresetn)
        res.command != CMD_ATTR |-> !res.reset_attr && !res.fg_valid)
        else $error("attribute flags set outside attribute command");

endmodule

@@ sv/ansi_csi_escape_parser.sv @@
// ANSI CSI escape parser top level: input register, decode, result register.
// Depends on acep_pkg, acep_params and acep_decode.
//
// Usage:
//   s_ channel: one received terminal byte per beat in s_tdata[7:0].
//   m_ channel: exactly one display command per input byte, in order.
//   An input beat is registered at its accepting edge and decoded into the
//   result register when that register is free or being read, and
//   m_tvalid is driven from the result register.
//   Throughput is one byte per cycle while m_tready stays high: the decode
//   is a single short path between the input register and the result
//   register; parser state updates in the same cycle the result is loaded.
//   When the receiver stalls, the result register holds its beat, the
//   input register holds at most one more byte, s_tready then drops until
//   m_tready returns; no beat is lost or repeated.
//   Reset (aresetn low, synchronous) empties both registers and returns
//   the parser to plain text with all CSI fields cleared.
//   FIELD_BITS sets the saturation width of the decimal CSI fields.
module ansi_csi_escape_parser
    import acep_pkg::*;
#(
    parameter int unsigned FIELD_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [IN_W-1:0]    s_tdata,   // [7:0] byte_in
    output logic               m_tvalid,
    input  logic               m_tready,
    // [3:0] command, [11:4] char_code, [12] reset_attr, [13] fg_valid,
    // [16:14] fg_color, [33:17] arg0, [50:34] arg1, [55:51] zero
    output logic [TDATA_W-1:0] m_tdata
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    res_t       out_res_reg;
    logic       advance;
    res_t       res;
    par_ctrl_t  ctrl;
    par_info_t  info;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(TDATA_W - RES_W){1'b0}}, out_res_reg};

    acep_params #(
        .FIELD_BITS(FIELD_BITS)
    ) u_params (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .ch      (in_byte_reg),
        .info    (info)
    );

    acep_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .byte_q  (in_byte_reg),
        .info    (info),
        .ctrl    (ctrl),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (advance) begin
            out_res_reg <= res;
        end
    end

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled while a register is free");

endmodule
